// ===== rtl/core/lkc_pkg.sv =====
// Shared types and constants for the LRU key cache.
`timescale 1ns / 1ps
package lkc_pkg;

  localparam int unsigned KeyW   = 32;  // key field on the stream ports
  localparam int unsigned SlotW  = 3;   // reported slot field
  localparam int unsigned CountW = 4;   // reported held count field
  localparam int unsigned CapW   = 4;   // capacity register

  localparam logic [CapW-1:0] CapReset = 4'd8;

  localparam int unsigned InDataW  = 32;  // key, whole bytes
  localparam int unsigned OutDataW = 48;  // 41 result bits padded to whole bytes
  localparam int unsigned OutUsedW = 1 + SlotW + 1 + KeyW + CountW;

  // One result item as it leaves the directory.
  typedef struct packed {
    logic              hit;
    logic [SlotW-1:0]  slot;
    logic              evicted;
    logic [KeyW-1:0]   evicted_key;
    logic [CountW-1:0] held_count;
  } lkc_result_t;

endpackage

// ===== rtl/core/lkc_dir.sv =====
// Cache directory: key store, valid bits, recency ranks and their update.
`timescale 1ns / 1ps
module lkc_dir
  import lkc_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 8,
  parameter int unsigned KEY_WIDTH   = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 upd,       // apply the access this cycle
  input  logic [KEY_WIDTH-1:0] key,
  input  logic [CapW-1:0]      capacity,
  output lkc_result_t          result     // answer for key against current state
);

  localparam int unsigned IdxW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CntW  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CmpW  = (CntW > CapW) ? CntW : CapW;
  localparam int unsigned SelW  = (IdxW > SlotW) ? IdxW : SlotW;
  localparam int unsigned WideW = (KEY_WIDTH > KeyW) ? KEY_WIDTH : KeyW;
  localparam logic [CmpW-1:0] MaxEnt = CmpW'(MAX_ENTRIES);
  localparam logic [CmpW-1:0] OneCmp = CmpW'(1);

  logic [KEY_WIDTH-1:0] entry_key  [MAX_ENTRIES];
  logic [IdxW-1:0]      rank       [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid;
  logic [CntW-1:0]      count;

  logic [MAX_ENTRIES-1:0] hit_vec;
  logic [MAX_ENTRIES-1:0] victim_vec;
  logic                 hit;
  logic                 room;
  logic [IdxW-1:0]      hit_idx;
  logic [IdxW-1:0]      hit_rank;
  logic [IdxW-1:0]      free_idx;
  logic [IdxW-1:0]      victim_idx;
  logic [KEY_WIDTH-1:0] victim_key;
  logic [IdxW-1:0]      sel;
  logic [IdxW-1:0]      old_rank;
  logic [CmpW-1:0]      count_ext;
  logic [CmpW-1:0]      cap_eff;
  logic [CntW-1:0]      count_next;

  // Parallel lookup: hit lanes, lowest free slot, least recent entry.
  always_comb begin
    count_ext = CmpW'(count);
    if (CmpW'(capacity) == '0) begin
      cap_eff = OneCmp;
    end else if (CmpW'(capacity) > MaxEnt) begin
      cap_eff = MaxEnt;
    end else begin
      cap_eff = CmpW'(capacity);
    end
    hit_idx    = '0;
    hit_rank   = '0;
    victim_idx = '0;
    victim_key = '0;
    free_idx   = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_vec[i]    = valid[i] && (entry_key[i] == key);
      // Ranks of valid entries are always 0..count-1, so the oldest is unique.
      victim_vec[i] = valid[i] && (CmpW'(rank[i]) == count_ext - OneCmp);
      if (hit_vec[i]) begin
        hit_idx  = hit_idx | IdxW'(i);
        hit_rank = hit_rank | rank[i];
      end
      if (victim_vec[i]) begin
        victim_idx = victim_idx | IdxW'(i);
        victim_key = victim_key | entry_key[i];
      end
    end
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_idx = IdxW'(i);
      end
    end
    hit  = |hit_vec;
    room = !hit && (count_ext < cap_eff);
    if (hit) begin
      sel      = hit_idx;
      old_rank = hit_rank;
    end else if (room) begin
      sel      = free_idx;
      old_rank = IdxW'(count);
    end else begin
      sel      = victim_idx;
      old_rank = IdxW'(count_ext - OneCmp);
    end
    count_next = room ? count + CntW'(1) : count;
  end

  always_comb begin
    result.hit         = hit;
    result.slot        = SelW'(sel) >> 0;
    result.evicted     = !hit && !room;
    result.evicted_key = (!hit && !room) ? KeyW'(WideW'(victim_key)) : '0;
    result.held_count  = CountW'(CmpW'(count_next));
  end

  // Key store: no reset, entries are read only once valid.
  always_ff @(posedge clk) begin
    if (upd) begin
      entry_key[sel] <= key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else if (upd) begin
      valid[sel] <= 1'b1;
      count      <= count_next;
      // Promote: every entry more recent than the accessed one ages by one.
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (IdxW'(i) == sel) begin
          rank[i] <= '0;
        end else if (valid[i] && (rank[i] < old_rank)) begin
          rank[i] <= rank[i] + IdxW'(1);
        end
      end
    end
  end

  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    CntW'($countones(valid)) == count)
    else $error("held count differs from number of valid entries");

  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    $onehot0(hit_vec))
    else $error("key matched in more than one entry");

  a_victim_exists: assert property (@(posedge clk) disable iff (rst)
    (upd && !hit && !room) |-> $onehot(victim_vec))
    else $error("eviction without a unique least recent entry");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CmpW'(count) <= MaxEnt)
    else $error("held count above entry count");

  a_promoted_rank: assert property (@(posedge clk) disable iff (rst)
    upd |=> (rank[$past(sel)] == '0))
    else $error("accessed entry not made most recent");

endmodule

// ===== rtl/core/lru_key_cache.sv =====
// Top level of the LRU key cache: stream handshakes, capacity register, result register.
`timescale 1ns / 1ps
// Path: a key accepted into the input register is looked up and applied when it advances,
//   where its result lands in the output register and m_tvalid rises.
// Throughput: one item per cycle while the output is not stalled; the lookup, victim choice and
//   rank update of the directory are combinational, so back-to-back keys see each other's updates.
// Reset (rst, synchronous): clears valid bits, ranks, held count and both stages;
//   capacity returns to 8. The key store is not cleared and needs no clearing pass.
module lru_key_cache
  import lkc_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 8,
  parameter int unsigned KEY_WIDTH   = 32
) (
  input  logic                clk,
  input  logic                rst,
  // Capacity write channel.
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CapW-1:0]     cfg_data,    // capacity
  // Key input.
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [InDataW-1:0]  s_tdata,     // [31:0] key
  // Result output.
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata      // [0] hit, [3:1] slot, [4] evicted,
                                           // [36:5] evicted_key, [40:37] held_count,
                                           // [47:41] zero
);

  localparam int unsigned WideW = (KEY_WIDTH > KeyW) ? KEY_WIDTH : KeyW;

  logic [CapW-1:0]      capacity;
  logic                 in_valid;
  logic [KEY_WIDTH-1:0] in_key;
  logic                 out_valid;
  lkc_result_t          out_res;
  lkc_result_t          dir_res;
  logic                 advance;

  // The user must write capacity only while idle; the block itself does not enforce it and takes every write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CapReset;
    end else if (cfg_valid) begin
      capacity <= cfg_data;
    end
  end

  // Advance the held key into the directory when the result register is free
  // or drains this cycle; refill the input register in the same cycle.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // Key register: narrow or widen the stream key to the stored width.
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_key <= KEY_WIDTH'(WideW'(s_tdata));
    end
  end

  lkc_dir #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_dir (
    .clk      (clk),
    .rst      (rst),
    .upd      (advance),
    .key      (in_key),
    .capacity (capacity),
    .result   (dir_res)
  );

  // Result register: hold until taken, load on each advance.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= dir_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OutDataW - OutUsedW){1'b0}},
                     out_res.held_count,
                     out_res.evicted_key,
                     out_res.evicted,
                     out_res.slot,
                     out_res.hit};

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result changed while stalled");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(out_res.hit && out_res.evicted))
    else $error("hit reported together with an eviction");

  a_evict_key_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !out_res.evicted) |-> (out_res.evicted_key == '0))
    else $error("evicted key nonzero without an eviction");

endmodule
